[design/esdt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Encoder speed and distance tracker package
// Shared widths, register indexes and the status type of the divider.
// ----------------------------------------------------------------------------
package esdt_pkg;

  localparam int CPR_W       = 15;
  localparam int POLE_W      = 8;
  localparam int COUNT_W     = 16;
  localparam int FRAC_W      = 16;
  localparam int FILT_W      = 32;
  localparam int DIST_W      = 48;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 120;
  localparam int CFG_IDX_W   = 1;

  localparam logic [CFG_IDX_W-1:0] REG_COUNTS_PER_REV = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POLE_FACTOR    = 1'd1;

  localparam logic [CPR_W-1:0]  CPR_RESET   = 15'd1024;
  localparam logic [POLE_W-1:0] POLE_RESET  = 8'd1;
  localparam logic [15:0]       SPEED_GAIN  = 16'd100;

  localparam logic FUNC_TICK  = 1'b0;
  localparam logic FUNC_RESET = 1'b1;

  typedef struct packed {
    logic busy;
    logic done;
  } esdt_div_sts_t;

endpackage
`default_nettype wire

[design/encoder_speed_distance_tracker_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Encoder speed and distance tracker
// Scales one encoder counter sample per beat, steps whole revolutions, keeps
// a moving-average window of the pulse speed and reports averaged speed in
// signed Q16.16 and distance in signed Q32.16 revolutions.
// ----------------------------------------------------------------------------
// A sample tick is scaled and stepped in S_CALC, then goes through S_DIV_DIST,
// S_POST_DIST, S_DIV_FILT and S_POST_FILT to S_OUT, where its result beat is
// loaded once the output register is free. Both the distance and the averaged
// speed go through one shared divider that yields one quotient bit per cycle,
// one after the other. A reset command goes straight from S_IDLE to S_OUT and
// its result beat is loaded there in the same way. The input is not ready while
// a beat is being worked on; a finished result waits in the output register.
module encoder_speed_distance_tracker_top #(
  parameter int WINDOW_LEN = 8
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // tdata: raw_count[15:0]
  input  wire logic [esdt_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,
  // tuser: func[0]
  input  wire logic                                s_axis_tuser_i,
  input  wire logic                                s_axis_tvalid_i,
  output logic                                     s_axis_tready_o,
  // tdata: speed_pulses[15:0], filtered_speed[47:16], revolutions[63:48],
  // distance[111:64], clear_counter[112], zero padding[119:113]
  output logic [esdt_pkg::OUT_TDATA_W-1:0]         m_axis_tdata_o,
  output logic                                     m_axis_tvalid_o,
  input  wire logic                                m_axis_tready_i,
  input  wire logic                                cfg_we_i,
  input  wire logic [esdt_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [esdt_pkg::CPR_W-1:0]          cfg_data_i
);
  import esdt_pkg::*;

  localparam int SUM_W = 16 + $clog2(WINDOW_LEN);
  localparam int NW    = (SUM_W + 17 > 40) ? SUM_W + 17 : 40;
  localparam int DW    = CPR_W + $clog2(WINDOW_LEN + 1);
  localparam int PW    = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_CALC      = 3'd1;
  localparam logic [2:0] S_DIV_DIST  = 3'd2;
  localparam logic [2:0] S_POST_DIST = 3'd3;
  localparam logic [2:0] S_DIV_FILT  = 3'd4;
  localparam logic [2:0] S_POST_FILT = 3'd5;
  localparam logic [2:0] S_OUT       = 3'd6;

  logic [2:0]               state_q;
  logic [CPR_W-1:0]         cpr_q;
  logic [POLE_W-1:0]        pole_q;
  logic [15:0]              prev_q;
  logic [15:0]              rev_q;
  logic [15:0]              rev_before_q;
  logic [PW-1:0]            ptr_q;
  logic signed [SUM_W-1:0]  sum_q;
  logic                     primed_q;
  logic                     fill_busy_q;
  logic [PW-1:0]            fill_idx_q;
  logic [15:0]              fill_val_q;
  logic signed [23:0]       full_q;
  logic [15:0]              speed_q;
  logic [FILT_W-1:0]        filt_q;
  logic [DIST_W-1:0]        dist_q;
  logic                     clr_q;
  logic [15:0]              rd_q;
  logic                     m_valid_q;
  logic [OUT_TDATA_W-1:0]   m_data_q;

  logic [15:0]              win_mem [WINDOW_LEN];

  logic                     in_acc;
  logic                     out_load;
  logic signed [24:0]       prod;
  logic [CPR_W-1:0]         cpr_eff;
  logic [15:0]              scaled;
  logic signed [16:0]       scaled_ext;
  logic signed [16:0]       cpr_pos;
  logic signed [16:0]       cpr_neg;
  logic                     step_up;
  logic                     step_dn;
  logic [15:0]              diff16;
  logic [15:0]              speed;
  logic                     full_neg;
  logic [23:0]              full_abs;
  logic                     sum_neg;
  logic [SUM_W-1:0]         sum_abs;
  logic [NW-1:0]            dvd_dist;
  logic [DW-1:0]            dvs_filt;
  logic [NW-1:0]            dvd_filt;
  logic                     div_start;
  logic [NW-1:0]            div_dvd;
  logic [DW-1:0]            div_dvs;
  esdt_div_sts_t            div_sts;
  logic [NW-1:0]            quo;
  logic [DIST_W-1:0]        quo48;
  logic [DIST_W-1:0]        rev48;
  logic [FILT_W-1:0]        filt_sat;
  logic [PW-1:0]            ptr_nxt;
  logic                     mem_we;
  logic [PW-1:0]            mem_addr;
  logic [15:0]              mem_wdata;
  logic signed [SUM_W-1:0]  sum_new;

  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_load = (state_q == S_OUT) && (!m_valid_q || m_axis_tready_i);

  assign prod       = $signed({1'b0, pole_q}) * $signed(s_axis_tdata_i);
  assign cpr_eff    = (cpr_q == '0) ? CPR_W'(1) : cpr_q;
  assign scaled     = full_q[15:0];
  assign scaled_ext = $signed({scaled[15], scaled});
  assign cpr_pos    = $signed({2'b00, cpr_eff});
  assign cpr_neg    = -cpr_pos;
  assign step_up    = scaled_ext >= cpr_pos;
  assign step_dn    = scaled_ext <= cpr_neg;
  assign diff16     = scaled - prev_q;
  assign speed      = 16'(diff16 * SPEED_GAIN);

  assign full_neg = full_q[23];
  assign full_abs = full_neg ? 24'(-full_q) : 24'(full_q);
  assign dvd_dist = NW'({full_abs, 16'h0000}) + NW'(cpr_eff >> 1);

  assign sum_neg  = sum_q[SUM_W-1];
  assign sum_abs  = sum_neg ? SUM_W'(-sum_q) : SUM_W'(sum_q);
  assign dvs_filt = DW'(cpr_eff) * DW'(WINDOW_LEN);
  assign dvd_filt = NW'({sum_abs, 16'h0000}) + NW'(dvs_filt >> 1);

  assign div_start = (state_q == S_CALC) || (state_q == S_POST_DIST);
  assign div_dvd   = (state_q == S_CALC) ? dvd_dist : dvd_filt;
  assign div_dvs   = (state_q == S_CALC) ? DW'(cpr_eff) : dvs_filt;

  esdt_divider #(
    .NW (NW),
    .DW (DW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .sts_o      (div_sts),
    .quotient_o (quo)
  );

  assign quo48 = DIST_W'(quo);
  assign rev48 = {{16{rev_before_q[15]}}, rev_before_q, 16'h0000};

  always_comb begin
    if (sum_neg) begin
      if (|quo[NW-1:32] || (quo[31] && |quo[30:0])) begin
        filt_sat = 32'h8000_0000;
      end else begin
        filt_sat = 32'(-quo[31:0]);
      end
    end else begin
      if (|quo[NW-1:31]) begin
        filt_sat = 32'h7FFF_FFFF;
      end else begin
        filt_sat = quo[31:0];
      end
    end
  end

  assign ptr_nxt = (ptr_q == PW'(WINDOW_LEN - 1)) ? '0 : ptr_q + 1'b1;
  assign sum_new = primed_q ? SUM_W'(sum_q - SUM_W'($signed(rd_q)) + SUM_W'($signed(speed)))
                            : SUM_W'(SUM_W'($signed(speed)) * SUM_W'(WINDOW_LEN));

  assign mem_we    = (state_q == S_CALC) || fill_busy_q;
  assign mem_addr  = (state_q == S_CALC) ? ptr_q : fill_idx_q;
  assign mem_wdata = (state_q == S_CALC) ? speed : fill_val_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      win_mem[mem_addr] <= mem_wdata;
    end
    rd_q <= win_mem[ptr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cpr_q       <= CPR_RESET;
      pole_q      <= POLE_RESET;
      prev_q      <= '0;
      rev_q       <= '0;
      ptr_q       <= '0;
      sum_q       <= '0;
      primed_q    <= 1'b0;
      fill_busy_q <= 1'b0;
      m_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_COUNTS_PER_REV: cpr_q  <= cfg_data_i;
          REG_POLE_FACTOR:    pole_q <= cfg_data_i[POLE_W-1:0];
          default: ;
        endcase
      end

      if (fill_busy_q && fill_idx_q == PW'(WINDOW_LEN - 1)) begin
        fill_busy_q <= 1'b0;
      end

      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            if (s_axis_tuser_i == FUNC_RESET) begin
              rev_q   <= '0;
              prev_q  <= '0;
              state_q <= S_OUT;
            end else begin
              state_q <= S_CALC;
            end
          end
        end
        S_CALC: begin
          if (step_up) begin
            rev_q  <= rev_q + 1'b1;
            prev_q <= '0;
          end else if (step_dn) begin
            rev_q  <= rev_q - 1'b1;
            prev_q <= '0;
          end else begin
            prev_q <= scaled;
          end
          sum_q <= sum_new;
          ptr_q <= ptr_nxt;
          if (!primed_q) begin
            primed_q    <= 1'b1;
            fill_busy_q <= 1'b1;
          end
          state_q <= S_DIV_DIST;
        end
        S_DIV_DIST: begin
          if (div_sts.done) begin
            state_q <= S_POST_DIST;
          end
        end
        S_POST_DIST: begin
          state_q <= S_DIV_FILT;
        end
        S_DIV_FILT: begin
          if (div_sts.done) begin
            state_q <= S_POST_FILT;
          end
        end
        S_POST_FILT: begin
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      full_q <= prod[23:0];
      if (s_axis_tuser_i == FUNC_RESET) begin
        speed_q <= '0;
        filt_q  <= '0;
        dist_q  <= '0;
        clr_q   <= 1'b1;
      end
    end
    if (state_q == S_CALC) begin
      speed_q      <= speed;
      clr_q        <= step_up || step_dn;
      rev_before_q <= rev_q;
      if (!primed_q) begin
        fill_idx_q <= '0;
        fill_val_q <= speed;
      end
    end
    if (fill_busy_q) begin
      fill_idx_q <= fill_idx_q + 1'b1;
    end
    if (state_q == S_POST_DIST) begin
      dist_q <= rev48 + (full_neg ? DIST_W'(-quo48) : quo48);
    end
    if (state_q == S_POST_FILT) begin
      filt_q <= filt_sat;
    end
    if (out_load) begin
      m_data_q <= {7'b0000000, clr_q, dist_q, rev_q, filt_q, speed_q};
    end
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

endmodule
`default_nettype wire

[design/esdt_divider.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Encoder tracker serial divider
// Unsigned restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module esdt_divider #(
  parameter int NW = 40,
  parameter int DW = 19
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire logic [NW-1:0]          dividend_i,
  input  wire logic [DW-1:0]          divisor_i,
  output esdt_pkg::esdt_div_sts_t     sts_o,
  output logic      [NW-1:0]          quotient_o
);
  import esdt_pkg::*;

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] acc_q;
  logic [DW-1:0] rem_q;
  logic [DW-1:0] dvs_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic          done_q;

  logic [DW:0]   shifted;
  logic [DW:0]   diff;
  logic          ge;

  assign shifted = {rem_q, acc_q[NW-1]};
  assign diff    = shifted - {1'b0, dvs_q};
  assign ge      = shifted >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CW'(NW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      acc_q <= {acc_q[NW-2:0], ge};
      rem_q <= ge ? diff[DW-1:0] : shifted[DW-1:0];
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign quotient_o = acc_q;

endmodule
`default_nettype wire

[design/esdt_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Encoder tracker port checker
// Watches the stream ports of the tracker over time.
// ----------------------------------------------------------------------------
module esdt_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              s_axis_tvalid_i,
  input wire logic                              s_axis_tready_o,
  input wire logic                              s_axis_tuser_i,
  input wire logic                              m_axis_tvalid_o,
  input wire logic                              m_axis_tready_i,
  input wire logic [esdt_pkg::OUT_TDATA_W-1:0]  m_axis_tdata_o
);
  import esdt_pkg::*;

  logic in_acc;

  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;

  // The block works on one beat at a time.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready_o)
    else $error("input ready right after an accepted beat");

  // No result can show up in the cycle after a beat is taken.
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !$rose(m_axis_tvalid_o))
    else $error("result appeared too early");

  // A reset command with a free output slot yields a zero result asking for a clear.
  a_reset_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tuser_i == FUNC_RESET && !m_axis_tvalid_o) |-> ##2
      (m_axis_tvalid_o && m_axis_tdata_o[111:0] == '0 && m_axis_tdata_o[112]))
    else $error("reset command result is wrong");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      (m_axis_tvalid_o && $stable(m_axis_tdata_o)))
    else $error("stalled output beat changed");

endmodule

bind encoder_speed_distance_tracker_top esdt_checker u_esdt_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
`default_nettype wire
